### sv/bec_pkg.sv
`timescale 1ns / 1ps

package bec_pkg;

  // Sizes
  localparam int SAMPLE_WIDTH      = 16;
  localparam int BANDPASS_SECTIONS = 2;
  localparam int SINE_TABLE_DEPTH  = 1024;   // power of two
  localparam int SECTION_COUNT     = BANDPASS_SECTIONS + 1;
  localparam int TAPS_PER_SEC      = 5;
  localparam int COEF_SLOTS        = SECTION_COUNT * TAPS_PER_SEC;

  localparam int SEC_W        = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam int SLOT_W       = $clog2(COEF_SLOTS);
  localparam int COEF_INDEX_W = 4;
  localparam int COEF_W       = 32;     // Q4.28
  localparam int COEF_FRAC    = 28;
  localparam int SIG_W        = 32;     // Q8.24
  localparam int DELAY_W      = 40;     // Q16.24
  localparam int SUM_W        = DELAY_W + 2;
  localparam int PROD_W       = 2 * COEF_W;
  localparam int RND_W        = PROD_W - COEF_FRAC;
  localparam int SINE_W       = 16;     // Q1.15
  localparam int SINE_ADDR_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int PHASE_W      = 32;
  localparam int IN_SHIFT     = 25 - SAMPLE_WIDTH;
  localparam int OUT_SHIFT    = 40 - SAMPLE_WIDTH;

  // Stream word layout
  localparam int IDX_LSB    = SAMPLE_WIDTH;
  localparam int VAL_LSB    = SAMPLE_WIDTH + COEF_INDEX_W;
  localparam int IN_DATA_W  = ((VAL_LSB + COEF_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  // Edges from a sample word's acceptance to the edge that samples its result
  localparam int ITEM_LATENCY = COEF_SLOTS + 3;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd17895697;
  localparam logic [63:0]        HALF_PI_Q30      = 64'd1686629713;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_COEF   = 1'b1
  } op_t;

  // Product kinds in issue order within one section, then the carrier product
  typedef enum logic [2:0] {
    K_B0,
    K_B1,
    K_A1,
    K_B2,
    K_A2,
    K_CAR
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_CAR,
    S_DONE
  } state_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic             load;
    logic             issue;
    logic [SEC_W-1:0] sec;
    kind_t            kind;
  } ctl_t;

  typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

  // Quarter-wave Taylor series in Q2.30, scaled to 32767
  function automatic sine_tab_t build_sine();
    sine_tab_t          tab;
    logic [63:0]        p;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    logic [1:0]         q;
    int                 k;
    for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
      p = (64'(k) << 32) / SINE_TABLE_DEPTH;
      q = p[31:30];
      r = p & 64'h3FFF_FFFF;
      if (q[0]) r = 64'h4000_0000 - r;
      x   = (r * HALF_PI_Q30) >> 30;
      x2  = (x * x) >> 30;
      t   = x;
      sum = $signed(x);
      t   = ((t * x2) >> 30) / 64'd6;
      sum = sum - $signed(t);
      t   = ((t * x2) >> 30) / 64'd20;
      sum = sum + $signed(t);
      t   = ((t * x2) >> 30) / 64'd42;
      sum = sum - $signed(t);
      t   = ((t * x2) >> 30) / 64'd72;
      sum = sum + $signed(t);
      t   = ((t * x2) >> 30) / 64'd110;
      sum = sum - $signed(t);
      t   = ((t * x2) >> 30) / 64'd156;
      sum = sum + $signed(t);
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
      if (v > 64'sd32767) v = 64'sd32767;
      tab[k] = q[1] ? SINE_W'(-v) : SINE_W'(v);
    end
    return tab;
  endfunction

endpackage

### sv/bec_coef_bank.sv
`timescale 1ns / 1ps

module bec_coef_bank
  import bec_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [COEF_INDEX_W-1:0]  wr_index,
  input  logic [COEF_W-1:0]        wr_data,
  input  ctl_t                     ctl,
  output logic signed [COEF_W-1:0] rd_data
);

  logic [COEF_W-1:0] coef [COEF_SLOTS];
  logic [SLOT_W-1:0] tap_off;
  logic [SLOT_W-1:0] rd_slot;

  // Map product kind to its tap within a section (b0 b1 b2 a1 a2)
  always_comb begin
    unique case (ctl.kind)
      K_B0:    tap_off = SLOT_W'(0);
      K_B1:    tap_off = SLOT_W'(1);
      K_B2:    tap_off = SLOT_W'(2);
      K_A1:    tap_off = SLOT_W'(3);
      K_A2:    tap_off = SLOT_W'(4);
      default: tap_off = SLOT_W'(0);
    endcase
    rd_slot = SLOT_W'(32'(ctl.sec) * TAPS_PER_SEC + 32'(tap_off));
    rd_data = $signed(coef[rd_slot]);
  end

  // Load one coefficient; drop writes beyond the table
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '{default: '0};
    end else if (wr_en && (32'(wr_index) < COEF_SLOTS)) begin
      coef[SLOT_W'(wr_index)] <= wr_data;
    end
  end

endmodule

### sv/bec_carrier.sv
`timescale 1ns / 1ps

module bec_carrier
  import bec_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [PHASE_W-1:0]       cfg_wdata,
  input  ctl_t                     ctl,
  output logic signed [SINE_W-1:0] sine
);

  localparam sine_tab_t SINE_ROM = build_sine();

  logic [PHASE_W-1:0] phase_step;
  logic [PHASE_W-1:0] phase_acc;

  // Hold step register and advance phase once per carrier product
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= PHASE_STEP_RESET;
      phase_acc  <= '0;
    end else begin
      if (cfg_we) phase_step <= cfg_wdata;
      if (ctl.issue && (ctl.kind == K_CAR)) phase_acc <= phase_acc + phase_step;
    end
  end

  // Registered table read at the current phase
  always_ff @(posedge clk) begin
    sine <= SINE_ROM[phase_acc[PHASE_W-1 -: SINE_ADDR_W]];
  end

endmodule

### sv/bec_mac.sv
`timescale 1ns / 1ps

module bec_mac
  import bec_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  ctl_t                           ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [COEF_W-1:0]       coef,
  input  logic signed [SINE_W-1:0]       sine,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  localparam logic signed [PROD_W-1:0] ROUND_COEF = PROD_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [PROD_W-1:0] ROUND_OUT  = PROD_W'(1) <<< (OUT_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] OUT_MAX    = (PROD_W'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam logic signed [PROD_W-1:0] OUT_MIN    = -OUT_MAX - 1;
  localparam logic signed [SUM_W-1:0]  SIG_MAX    = (SUM_W'(1) <<< (SIG_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0]  SIG_MIN    = -SIG_MAX - 1;
  localparam logic signed [SUM_W-1:0]  DLY_MAX    = (SUM_W'(1) <<< (DELAY_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0]  DLY_MIN    = -DLY_MAX - 1;
  localparam logic signed [SIG_W-1:0]  SIG_TOP    = {1'b0, {(SIG_W - 1){1'b1}}};

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [SUM_W-1:0] v);
    if (v > SIG_MAX)      return SIG_MAX[SIG_W-1:0];
    else if (v < SIG_MIN) return SIG_MIN[SIG_W-1:0];
    else                  return v[SIG_W-1:0];
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_dly(input logic signed [SUM_W-1:0] v);
    if (v > DLY_MAX)      return DLY_MAX[DELAY_W-1:0];
    else if (v < DLY_MIN) return DLY_MIN[DELAY_W-1:0];
    else                  return v[DELAY_W-1:0];
  endfunction

  logic signed [DELAY_W-1:0] z1 [SECTION_COUNT];
  logic signed [DELAY_W-1:0] z2 [SECTION_COUNT];
  logic signed [SIG_W-1:0]   xin;
  logic signed [SIG_W-1:0]   yreg;
  logic signed [RND_W-1:0]   t_q;
  logic signed [PROD_W-1:0]  prod;
  logic                      acc_valid;
  kind_t                     acc_kind;
  logic [SEC_W-1:0]          acc_sec;

  logic signed [SIG_W-1:0]   sample_x;
  logic signed [SIG_W-1:0]   y_rect;
  logic signed [SIG_W-1:0]   sec_input;
  logic signed [SIG_W-1:0]   cur_x;
  logic signed [COEF_W-1:0]  op_a;
  logic signed [SIG_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  rnd_full;
  logic signed [RND_W-1:0]   rnd;
  logic signed [SUM_W-1:0]   y_sum;
  logic signed [SUM_W-1:0]   z1_sum;
  logic signed [SUM_W-1:0]   z2_sum;
  logic signed [PROD_W-1:0]  out_full;

  // Select multiplier operands
  always_comb begin
    sample_x = {{(SIG_W - SAMPLE_WIDTH - IN_SHIFT){sample[SAMPLE_WIDTH-1]}},
                sample, {IN_SHIFT{1'b0}}};
    if (!yreg[SIG_W-1])         y_rect = yreg;
    else if (yreg == -SIG_TOP - 1) y_rect = SIG_TOP;
    else                        y_rect = -yreg;
    if (ctl.sec == '0)                            sec_input = xin;
    else if (ctl.sec == SEC_W'(BANDPASS_SECTIONS)) sec_input = y_rect;
    else                                          sec_input = yreg;
    cur_x = (ctl.kind == K_B0) ? sec_input : xin;
    unique case (ctl.kind)
      K_B0, K_B1, K_B2: begin
        op_a = coef;
        op_b = cur_x;
      end
      K_A1, K_A2: begin
        op_a = coef;
        op_b = yreg;
      end
      default: begin
        op_a = {{(COEF_W - SINE_W){sine[SINE_W-1]}}, sine};
        op_b = yreg;
      end
    endcase
  end

  // Round the registered product, form section sums and the saturated output sample
  always_comb begin
    rnd_full = (prod + ROUND_COEF) >>> COEF_FRAC;
    rnd      = rnd_full[RND_W-1:0];
    y_sum    = SUM_W'(rnd) + SUM_W'(z1[acc_sec]);
    z1_sum   = SUM_W'(t_q) - SUM_W'(rnd) + SUM_W'(z2[acc_sec]);
    z2_sum   = SUM_W'(t_q) - SUM_W'(rnd);
    out_full = (prod + ROUND_OUT) >>> OUT_SHIFT;
    if (out_full > OUT_MAX)      result = OUT_MAX[SAMPLE_WIDTH-1:0];
    else if (out_full < OUT_MIN) result = OUT_MIN[SAMPLE_WIDTH-1:0];
    else                         result = out_full[SAMPLE_WIDTH-1:0];
  end

  // Update delay state
  always_ff @(posedge clk) begin
    if (rst) begin
      z1        <= '{default: '0};
      z2        <= '{default: '0};
      acc_valid <= 1'b0;
    end else begin
      acc_valid <= ctl.issue;
      if (acc_valid) begin
        unique case (acc_kind)
          K_A1:    z1[acc_sec] <= sat_dly(z1_sum);
          K_A2:    z2[acc_sec] <= sat_dly(z2_sum);
          default: ;
        endcase
      end
    end
  end

  // Multiply, latch section input, hold partial sums
  always_ff @(posedge clk) begin
    if (ctl.load) xin <= sample_x;
    else if (ctl.issue && (ctl.kind == K_B0)) xin <= cur_x;
    if (ctl.issue) begin
      prod     <= op_a * op_b;
      acc_kind <= ctl.kind;
      acc_sec  <= ctl.sec;
    end
    if (acc_valid) begin
      unique case (acc_kind)
        K_B0:       yreg <= sat_sig(y_sum);
        K_B1, K_B2: t_q  <= rnd;
        default:    ;
      endcase
    end
  end

endmodule

### sv/bec_seq.sv
`timescale 1ns / 1ps

module bec_seq
  import bec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_op,
  input  logic out_busy,
  output logic in_ready,
  output logic out_load,
  output ctl_t ctl
);

  state_t           state, state_next;
  logic [SEC_W-1:0] sec, sec_next;
  kind_t            kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sec   <= '0;
      kind  <= K_B0;
    end else begin
      state <= state_next;
      sec   <= sec_next;
      kind  <= kind_next;
    end
  end

  // Step through sections, then the carrier product, then write out
  always_comb begin
    state_next = state;
    sec_next   = sec;
    kind_next  = kind;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    ctl        = '{load: 1'b0, issue: 1'b0, sec: sec, kind: kind};
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_op == OP_SAMPLE)) begin
          ctl.load   = 1'b1;
          sec_next   = '0;
          kind_next  = K_B0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        ctl.issue = 1'b1;
        unique case (kind)
          K_B0: kind_next = K_B1;
          K_B1: kind_next = K_A1;
          K_A1: kind_next = K_B2;
          K_B2: kind_next = K_A2;
          K_A2: begin
            kind_next = K_B0;
            if (sec == SEC_W'(SECTION_COUNT - 1)) state_next = S_CAR;
            else sec_next = sec + 1'b1;
          end
          default: kind_next = K_B0;
        endcase
      end
      S_CAR: begin
        ctl.issue  = 1'b1;
        ctl.kind   = K_CAR;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### sv/bandpass_envelope_carrier_modulator.sv
`timescale 1ns / 1ps
// Channel   Signals                        Contents (low bit first)
// -------   ----------------------------   ------------------------------------------
// input     s_axis_tvalid/tready/tdata     sample_in, coef_index, coef_value, zero pad
//           s_axis_tuser, s_axis_tlast     op; last_in
// output    m_axis_tvalid/tready/tdata     sample_out
//           m_axis_tlast                   last_out
// config    cfg_we, cfg_wdata              phase_step
//
// A sample word closes the input until its result is loaded into the output register: one
// shared 32x32 multiplier forms five products per biquad section (three sections) and
// the carrier product in turn, after which the sequencer rounds and writes out the
// carrier product. A coefficient word is written on acceptance and leaves the input
// open.
// Reset (rst, synchronous) clears coefficients, filter delays and phase and loads
// the default phase step. A stalled result sits in the output register; the next
// sample is taken meanwhile and waits at its write-out until the register frees.

module bandpass_envelope_carrier_modulator
  import bec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample_in, coef_index, coef_value
  input  logic                  s_axis_tuser,   // op
  input  logic                  s_axis_tlast,   // last_in
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // sample_out
  output logic                  m_axis_tlast,   // last_out
  input  logic                  cfg_we,
  input  logic [PHASE_W-1:0]    cfg_wdata
);

  ctl_t                           ctl;
  logic                           out_load;
  logic                           out_busy;
  logic                           accept;
  logic                           last_q;
  logic signed [COEF_W-1:0]       coef;
  logic signed [SINE_W-1:0]       sine;
  logic signed [SAMPLE_WIDTH-1:0] result;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_busy = m_axis_tvalid && !m_axis_tready;

  bec_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .out_busy (out_busy),
    .in_ready (s_axis_tready),
    .out_load (out_load),
    .ctl      (ctl)
  );

  bec_coef_bank u_coef (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && (s_axis_tuser == OP_COEF)),
    .wr_index (s_axis_tdata[IDX_LSB +: COEF_INDEX_W]),
    .wr_data  (s_axis_tdata[VAL_LSB +: COEF_W]),
    .ctl      (ctl),
    .rd_data  (coef)
  );

  bec_carrier u_carrier (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .sine      (sine)
  );

  bec_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .coef   (coef),
    .sine   (sine),
    .result (result)
  );

  // Keep the frame mark of the sample in flight
  always_ff @(posedge clk) begin
    if (ctl.load) last_q <= s_axis_tlast;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= OUT_DATA_W'($unsigned(result));
      m_axis_tlast <= last_q;
    end
  end

endmodule

### sv/bec_checker.sv
`timescale 1ns / 1ps

module bec_checker
  import bec_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // A sample word keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SAMPLE) |=> !s_axis_tready)
    else $error("input open during sample work");

  // A coefficient word leaves the input open for the next word
  a_coef_quick: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_COEF) |=> s_axis_tready)
    else $error("coefficient write held the input");

  // A sample taken with the output empty shows its result without waiting at write-out
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SAMPLE) && !m_axis_tvalid
      |-> ##ITEM_LATENCY m_axis_tvalid)
    else $error("result missing after sample latency");

endmodule

bind bandpass_envelope_carrier_modulator bec_checker u_checker (.*);

### dv/bandpass_envelope_carrier_modulator_test.sv
`timescale 1ns / 1ps

module bandpass_envelope_carrier_modulator_test;
  import bec_pkg::*;

  // Tap order inside one section's five coefficient slots
  localparam int TAP_B0 = 0;
  localparam int TAP_B1 = 1;
  localparam int TAP_B2 = 2;
  localparam int TAP_A1 = 3;
  localparam int TAP_A2 = 4;

  localparam int          ONE_Q28     = 1 << COEF_FRAC;
  localparam int          A2_MAX      = 241591910;   // 0.9 in Q4.28
  localparam int          PHASES      = 7;
  localparam int          WORDS_PER_PHASE = 140;
  localparam int          LONG_HOLD   = 400;
  localparam int          STALL_LIMIT = 4000;
  localparam int          SETTLE      = ITEM_LATENCY + 4;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } env_word_t;

  // Tracks filter, carrier and phase state and queues the modulated samples due out
  class envelope_scoreboard;
    logic signed [SINE_W-1:0] carrier_rom [SINE_TABLE_DEPTH];
    logic [COEF_W-1:0]        coefs [COEF_SLOTS];
    longint                   delays [2*SECTION_COUNT];
    logic [PHASE_W-1:0]       phase;
    logic [PHASE_W-1:0]       step;
    env_word_t                due_q [$];
    int                       errors;

    function new();
      make_carrier();
      foreach (coefs[i]) coefs[i] = '0;
      foreach (delays[i]) delays[i] = 0;
      phase  = '0;
      step   = PHASE_STEP_RESET;
      errors = 0;
    endfunction

    // Quarter-wave Taylor series in Q2.30, six terms past the first
    function void make_carrier();
      bit [63:0] p;
      bit [63:0] frac;
      bit [63:0] x;
      bit [63:0] x2;
      bit [63:0] term;
      longint    acc;
      longint    v;
      bit [1:0]  quad;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
        p    = (64'(k) << 32) / SINE_TABLE_DEPTH;
        quad = p[31:30];
        frac = p & 64'h3FFF_FFFF;
        if (quad[0]) frac = 64'h4000_0000 - frac;
        x    = (frac * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) acc = acc - longint'(term);
          else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > (longint'(1) <<< 30)) acc = longint'(1) <<< 30;
        v = (acc * 32767 + (longint'(1) <<< 29)) >>> 30;
        if (v > 32767) v = 32767;
        carrier_rom[k] = quad[1] ? SINE_W'(-v) : SINE_W'(v);
      end
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // Round a Q4.28 x Q8.24 product back to Q8.24, halves toward plus infinity
    function longint round_q28(longint v);
      return (v + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function longint tap(int sec, int t);
      return longint'($signed(coefs[sec * TAPS_PER_SEC + t]));
    endfunction

    // Transposed direct form II biquad
    function longint run_biquad(int sec, longint x);
      longint y;
      y = clamp(round_q28(tap(sec, TAP_B0) * x) + delays[2*sec], SIG_W);
      delays[2*sec] = clamp(round_q28(tap(sec, TAP_B1) * x)
                            - round_q28(tap(sec, TAP_A1) * y) + delays[2*sec+1], DELAY_W);
      delays[2*sec+1] = clamp(round_q28(tap(sec, TAP_B2) * x)
                              - round_q28(tap(sec, TAP_A2) * y), DELAY_W);
      return y;
    endfunction

    function void set_step(logic [PHASE_W-1:0] v);
      step = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // Apply one accepted input word
    function void take_word(op_t op, logic [SAMPLE_WIDTH-1:0] smp, logic lst,
                            logic [COEF_INDEX_W-1:0] idx, logic [COEF_W-1:0] val);
      longint    s;
      longint    prod;
      env_word_t w;
      if (op == OP_COEF) begin
        if (idx < COEF_SLOTS) coefs[idx] = val;
        return;
      end
      s = longint'($signed(smp)) * (longint'(1) <<< IN_SHIFT);
      for (int sec = 0; sec < BANDPASS_SECTIONS; sec++) s = run_biquad(sec, s);
      if (s < 0) s = -s;
      if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
      s = run_biquad(BANDPASS_SECTIONS, s);
      prod = s * longint'(carrier_rom[phase[PHASE_W-1 -: SINE_ADDR_W]]);
      prod = clamp((prod + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT, SAMPLE_WIDTH);
      phase = phase + step;
      w.sample = SAMPLE_WIDTH'(prod);
      w.last   = lst;
      due_q.push_back(w);
    endfunction

    // Compare one accepted output word with the oldest expectation
    function void check_word(logic [SAMPLE_WIDTH-1:0] smp, logic lst);
      env_word_t w;
      if (due_q.size() == 0) begin
        $error("unexpected output word: sample_out %0d last_out %0b", $signed(smp), lst);
        errors++;
        return;
      end
      w = due_q.pop_front();
      if (smp !== w.sample) begin
        $error("sample_out: expected %0d, actual %0d", w.sample, $signed(smp));
        errors++;
      end
      if (lst !== w.last) begin
        $error("last_out: expected %0b, actual %0b", w.last, lst);
        errors++;
      end
    endfunction

    function void close_out();
      if (due_q.size() != 0) begin
        $error("%0d output words never arrived", due_q.size());
        errors += due_q.size();
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // sample_in, coef_index, coef_value
  logic                  s_axis_tuser;   // op
  logic                  s_axis_tlast;   // last_in
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // sample_out
  logic                  m_axis_tlast;   // last_out
  logic                  cfg_we;
  logic [PHASE_W-1:0]    cfg_wdata;

  envelope_scoreboard sb;
  bit                 quiet     = 1'b0;
  bit                 long_hold = 1'b0;
  int                 idle_cycles = 0;

  bandpass_envelope_carrier_modulator uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Track every handshake and config write at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_word(m_axis_tdata[SAMPLE_WIDTH-1:0], m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.take_word(op_t'(s_axis_tuser), s_axis_tdata[SAMPLE_WIDTH-1:0], s_axis_tlast,
                     s_axis_tdata[IDX_LSB +: COEF_INDEX_W], s_axis_tdata[VAL_LSB +: COEF_W]);
      if (cfg_we) sb.set_step(cfg_wdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
    end
  end

  // Abort when nothing moves for too long
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Output side: random stalls, one long hold-off on request, none when quiet
  initial begin : sink
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Offer one word and hold it until accepted; returns at the next falling edge
  task automatic send_word(input op_t op, input logic [SAMPLE_WIDTH-1:0] smp,
                           input logic lst, input logic [COEF_INDEX_W-1:0] idx,
                           input logic [COEF_W-1:0] val);
    logic [IN_DATA_W-1:0] word;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    word = '0;
    word[SAMPLE_WIDTH-1:0]       = smp;
    word[IDX_LSB +: COEF_INDEX_W] = idx;
    word[VAL_LSB +: COEF_W]       = val;
    s_axis_tdata  = word;
    s_axis_tuser  = op;
    s_axis_tlast  = lst;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] smp, input logic lst);
    send_word(OP_SAMPLE, smp, lst, COEF_INDEX_W'($urandom), $urandom);
  endtask

  task automatic send_coef(input int slot, input logic [COEF_W-1:0] val);
    send_word(OP_COEF, SAMPLE_WIDTH'($urandom), 1'($urandom), COEF_INDEX_W'(slot), val);
  endtask

  // Stop offering and wait until every expected word has come out
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write the phase step once the block is idle
  task automatic write_step(input logic [PHASE_W-1:0] v);
    drain();
    repeat (SETTLE) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // Load all three sections: stable biquads, or raw random words when wild
  task automatic load_coefs(input bit wild);
    int     a1;
    int     a2;
    longint lim;
    for (int sec = 0; sec < SECTION_COUNT; sec++) begin
      if (wild) begin
        for (int t = 0; t < TAPS_PER_SEC; t++) send_coef(sec * TAPS_PER_SEC + t, $urandom);
      end else begin
        a2  = int'($urandom_range(0, 2 * A2_MAX)) - A2_MAX;
        lim = (longint'(ONE_Q28 + a2) * 19) / 20;
        a1  = int'($urandom_range(0, int'(2 * lim))) - int'(lim);
        send_coef(sec * TAPS_PER_SEC + TAP_B0, int'($urandom_range(0, 2 * ONE_Q28)) - ONE_Q28);
        send_coef(sec * TAPS_PER_SEC + TAP_B1, int'($urandom_range(0, 2 * ONE_Q28)) - ONE_Q28);
        send_coef(sec * TAPS_PER_SEC + TAP_B2, int'($urandom_range(0, 2 * ONE_Q28)) - ONE_Q28);
        send_coef(sec * TAPS_PER_SEC + TAP_A1, a1);
        send_coef(sec * TAPS_PER_SEC + TAP_A2, a2);
      end
    end
  endtask

  initial begin : stimulus
    logic [PHASE_W-1:0] steps [PHASES];
    sb = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_SAMPLE;
    s_axis_tlast  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    steps = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0040_0000,
              32'h0, 32'h0, PHASE_STEP_RESET};
    steps[4] = $urandom;
    steps[5] = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero coefficients give zero out, and the first carrier sample is zero
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    // Pass each section straight through; the slot past the table is dropped
    send_coef(TAP_B0, ONE_Q28);
    send_coef(TAPS_PER_SEC + TAP_B0, ONE_Q28);
    send_coef(2 * TAPS_PER_SEC + TAP_B0, ONE_Q28);
    send_coef(COEF_SLOTS, 32'h7FFF_FFFF);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0001, 1'b0);
    // Push gain to the coefficient extremes so the output saturates
    send_coef(TAP_B0, 32'h8000_0000);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_coef(TAP_B0, 32'h7FFF_FFFF);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h4000, 1'b1);
    // Runaway feedback drives delays and section outputs into their limits
    send_coef(TAP_A1, 32'h8000_0000);
    send_coef(TAPS_PER_SEC + TAP_A2, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_sample(pick_sample(), 1'($urandom));

    for (int ph = 0; ph < PHASES; ph++) begin
      write_step(steps[ph]);
      quiet = (ph == PHASES - 1);
      load_coefs(ph % 4 == 3);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (ph == 2 && i == 20) long_hold = 1'b1;
        if (ph == 3 && i == 70) drain();
        if ($urandom_range(0, 31) == 0)
          send_coef($urandom_range(0, 15), $urandom);
        else
          send_sample(pick_sample(), $urandom_range(0, 15) == 0);
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk);
    sb.close_out();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
sv/bec_pkg.sv
sv/bec_coef_bank.sv
sv/bec_carrier.sv
sv/bec_mac.sv
sv/bec_seq.sv
sv/bandpass_envelope_carrier_modulator.sv
sv/bec_checker.sv
dv/bandpass_envelope_carrier_modulator_test.sv
